// ===== hw/rtl/mplm_pkg.sv =====
// mplm_pkg: shared constants and codes of the multi-pattern longest-match block
// used by mplm_ram and multi_pattern_longest_match; depends on nothing
`default_nettype none
package mplm_pkg;

	localparam int NODES_DEF    = 1024;
	localparam int ALPHABET_DEF = 26;
	localparam int MAX_LEN_DEF  = 255;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_BUILD = 2'd1,
		FUNC_SCAN  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BUILT = 2'd2;

endpackage
`default_nettype wire

// ===== hw/rtl/mplm_ram.sv =====
// mplm_ram: one-write one-read synchronous memory with registered read data
// depends on mplm_pkg for its default depth; sized by the parameters of the block top level
`default_nettype none
module mplm_ram #(
	parameter int DEPTH = mplm_pkg::NODES_DEF,
	parameter int WIDTH = 10
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_pattern_longest_match.sv =====
// multi_pattern_longest_match: pattern trie, failure-link build and text scan
// depends on mplm_pkg and mplm_ram
//
// Use: one request channel (func, symbol, last_of_pattern, new_text with
// req_valid/req_stall) and one result channel (match_length, status with
// res_valid/res_stall). Every request yields exactly one result, in order.
// Load letters do one child-table read and one write back.
// Scan letters read the child table for the letter, with a failure-link read
// and a retry for each failure link followed, and end with a length read.
// A build walks the trie breadth first: for each node taken from the queue it reads
// every trie row entry (ALPHABET per node), and for each child found follows the
// failure-link steps, all through single-port reads of the child table.
// After reset a clearing pass writes every child-table entry (NODES*ALPHABET
// entries, 26624 by default) and req_stall stays high during it.
// One request is worked at a time; a finished result sits in the output
// register, and while res_stall holds it the next request may be accepted
// and worked, its result waiting until the register is free.
`default_nettype none
module multi_pattern_longest_match #(
	parameter int NODES    = mplm_pkg::NODES_DEF,
	parameter int ALPHABET = mplm_pkg::ALPHABET_DEF,
	parameter int MAX_LEN  = mplm_pkg::MAX_LEN_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [1:0] func,
	input  wire logic [4:0] symbol,
	input  wire logic       last_of_pattern,
	input  wire logic       new_text,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [7:0]      match_length,
	output logic [1:0]      status
);

	localparam int NW = $clog2(NODES);
	localparam int SW = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
	localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN + 1) : 1;
	localparam int CD = NODES * ALPHABET;
	localparam int AW = $clog2(CD);

	typedef enum logic [19:0] {
		S_CLR   = 20'h00001,
		S_IDLE  = 20'h00002,
		S_LRD   = 20'h00004,
		S_LWB   = 20'h00008,
		S_SCH   = 20'h00010,
		S_SCHW  = 20'h00020,
		S_SFW   = 20'h00040,
		S_SLD   = 20'h00080,
		S_SLEN  = 20'h00100,
		S_BINIT = 20'h00200,
		S_BPOP  = 20'h00400,
		S_BCUR  = 20'h00800,
		S_BKID  = 20'h01000,
		S_BKIDW = 20'h02000,
		S_BFW   = 20'h04000,
		S_BFK   = 20'h08000,
		S_BFKW  = 20'h10000,
		S_BSET  = 20'h20000,
		S_BL1   = 20'h40000,
		S_BL2   = 20'h80000
	} state_t;

	state_t state_q;
	logic   fin_q;

	logic [AW-1:0] clr_q;
	logic [NW:0]   nodes_used_q;
	logic [NW-1:0] ins_cur_q, scan_q, cur_q, f_q, nx_q;
	logic [LW-1:0] pat_len_q, lf_q;
	logic          drop_q;
	logic [4:0]    sym_q;
	logic          last_q;
	logic [SW-1:0] i_q;
	logic [NW:0]   head_q, tail_q;
	logic [LW-1:0] pend_len_q;
	logic [1:0]    pend_st_q;
	logic          res_valid_q;
	logic [7:0]    match_length_q;
	logic [1:0]    status_q;

	// memory ports
	logic          c_we;
	logic [AW-1:0] c_wa, c_ra;
	logic [NW-1:0] c_wd, c_rd;
	logic          f_we;
	logic [NW-1:0] f_wa, f_wd, f_ra, f_rd;
	logic          l_we;
	logic [NW-1:0] l_wa, l_ra;
	logic [LW-1:0] l_wd, l_rd;
	logic          q_we;
	logic [NW-1:0] q_wa, q_wd, q_ra, q_rd;

	mplm_ram #(.DEPTH(CD), .WIDTH(NW)) u_child (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
	);
	mplm_ram #(.DEPTH(NODES), .WIDTH(NW)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
	);
	mplm_ram #(.DEPTH(NODES), .WIDTH(LW)) u_len (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);
	mplm_ram #(.DEPTH(NODES), .WIDTH(NW)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
	);

	function automatic logic [AW-1:0] caddr(input logic [NW-1:0] node, input int sym);
		int a;
		a = int'(node) * ALPHABET + sym;
		return AW'(a);
	endfunction

	// load letter evaluation, valid in S_LWB
	logic          ld_drop, ld_alloc, ld_wlen;
	logic [NW-1:0] ld_nx, ld_cur;
	logic [LW-1:0] ld_len;

	always_comb begin
		ld_drop  = drop_q;
		ld_alloc = 1'b0;
		ld_nx    = c_rd;
		ld_cur   = ins_cur_q;
		ld_len   = pat_len_q;
		if (!drop_q) begin
			if (int'(sym_q) >= ALPHABET) begin
				ld_drop = 1'b1;
			end else if (c_rd == '0) begin
				if (int'(nodes_used_q) + 1 < NODES) begin
					ld_alloc = 1'b1;
					ld_nx    = NW'(nodes_used_q + 1'b1);
				end else begin
					ld_drop = 1'b1;
				end
			end
			if (!ld_drop) begin
				ld_cur = ld_nx;
				if (int'(pat_len_q) < MAX_LEN) begin
					ld_len = pat_len_q + 1'b1;
				end
			end
		end
		ld_wlen = last_q && !ld_drop && (ld_cur != '0);
	end

	logic clr_in_nodes;
	assign clr_in_nodes = int'(clr_q) < NODES;

	always_comb begin
		c_we = 1'b0;
		c_wa = caddr(ins_cur_q, int'(sym_q));
		c_wd = ld_nx;
		c_ra = caddr(cur_q, int'(sym_q));
		f_we = 1'b0;
		f_wa = nx_q;
		f_wd = f_q;
		f_ra = cur_q;
		l_we = 1'b0;
		l_wa = nx_q;
		l_wd = lf_q;
		l_ra = cur_q;
		q_we = 1'b0;
		q_wa = tail_q[NW-1:0];
		q_wd = nx_q;
		q_ra = head_q[NW-1:0];
		case (state_q)
			S_CLR: begin
				c_we = 1'b1;
				c_wa = clr_q;
				c_wd = '0;
				f_we = clr_in_nodes;
				f_wa = clr_q[NW-1:0];
				f_wd = '0;
				l_we = clr_in_nodes;
				l_wa = clr_q[NW-1:0];
				l_wd = '0;
			end
			S_LRD: c_ra = caddr(ins_cur_q, int'(sym_q));
			S_LWB: begin
				c_we = ld_alloc;
				l_we = ld_wlen;
				l_wa = ld_cur;
				l_wd = ld_len;
			end
			S_BINIT: begin
				q_we = 1'b1;
				q_wa = '0;
				q_wd = '0;
			end
			S_BKID: c_ra = caddr(cur_q, int'(i_q));
			S_BKIDW: f_ra = cur_q;
			S_BFK: c_ra = caddr(f_q, int'(i_q));
			S_BFKW: f_ra = f_q;
			S_BSET: begin
				f_we = 1'b1;
				l_ra = f_q;
			end
			S_BL1: l_ra = nx_q;
			S_BL2: begin
				l_we = lf_q > l_rd;
				q_we = int'(tail_q) < NODES;
			end
			default: ;
		endcase
	end

	logic take, out_free;
	assign take      = req_valid && (state_q == S_IDLE) && !fin_q;
	assign out_free  = !res_valid_q || !res_stall;
	assign req_stall = (state_q != S_IDLE) || fin_q;

	logic [LW+7:0] len_ext;
	assign len_ext = {8'b0, pend_len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			fin_q        <= 1'b0;
			clr_q        <= '0;
			nodes_used_q <= '0;
			ins_cur_q    <= '0;
			scan_q       <= '0;
			cur_q        <= '0;
			f_q          <= '0;
			nx_q         <= '0;
			lf_q         <= '0;
			sym_q        <= '0;
			last_q       <= 1'b0;
			i_q          <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			pend_len_q   <= '0;
			pend_st_q    <= mplm_pkg::ST_OK;
			pat_len_q    <= '0;
			drop_q       <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (fin_q && out_free) begin
				fin_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CD - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						sym_q  <= symbol;
						last_q <= last_of_pattern;
						case (func)
							mplm_pkg::FUNC_LOAD: state_q <= S_LRD;
							mplm_pkg::FUNC_BUILD: state_q <= S_BINIT;
							mplm_pkg::FUNC_SCAN: begin
								if (int'(symbol) >= ALPHABET) begin
									cur_q   <= '0;
									state_q <= S_SLD;
								end else begin
									cur_q   <= new_text ? '0 : scan_q;
									state_q <= S_SCH;
								end
							end
							default: begin
								pend_len_q <= '0;
								pend_st_q  <= mplm_pkg::ST_OK;
								fin_q      <= 1'b1;
							end
						endcase
					end
				end
				S_LRD: state_q <= S_LWB;
				S_LWB: begin
					if (ld_alloc) begin
						nodes_used_q <= nodes_used_q + 1'b1;
					end
					pend_len_q <= '0;
					pend_st_q  <= ld_drop ? mplm_pkg::ST_FULL : mplm_pkg::ST_OK;
					if (last_q) begin
						ins_cur_q <= '0;
						pat_len_q <= '0;
						drop_q    <= 1'b0;
					end else begin
						ins_cur_q <= ld_cur;
						pat_len_q <= ld_len;
						drop_q    <= ld_drop;
					end
					fin_q   <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCH: state_q <= S_SCHW;
				S_SCHW: begin
					if (c_rd != '0) begin
						cur_q   <= c_rd;
						state_q <= S_SLD;
					end else if (cur_q == '0) begin
						state_q <= S_SLD;
					end else begin
						state_q <= S_SFW;
					end
				end
				S_SFW: begin
					// follow the failure link and retry the letter
					cur_q   <= f_rd;
					state_q <= S_SCH;
				end
				S_SLD: state_q <= S_SLEN;
				S_SLEN: begin
					scan_q     <= cur_q;
					pend_len_q <= l_rd;
					pend_st_q  <= mplm_pkg::ST_OK;
					fin_q      <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_BINIT: begin
					head_q  <= '0;
					tail_q  <= (NW+1)'(1);
					state_q <= S_BPOP;
				end
				S_BPOP: begin
					if (head_q == tail_q) begin
						scan_q     <= '0;
						pend_len_q <= '0;
						pend_st_q  <= mplm_pkg::ST_BUILT;
						fin_q      <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_BCUR;
					end
				end
				S_BCUR: begin
					cur_q   <= q_rd;
					i_q     <= '0;
					state_q <= S_BKID;
				end
				S_BKID: state_q <= S_BKIDW;
				S_BKIDW: begin
					nx_q <= c_rd;
					if (c_rd == '0) begin
						if (int'(i_q) == ALPHABET - 1) begin
							state_q <= S_BPOP;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_BKID;
						end
					end else if (cur_q == '0) begin
						f_q     <= '0;
						state_q <= S_BSET;
					end else begin
						state_q <= S_BFW;
					end
				end
				S_BFW: begin
					f_q     <= f_rd;
					state_q <= S_BFK;
				end
				S_BFK: state_q <= S_BFKW;
				S_BFKW: begin
					if (c_rd != '0) begin
						f_q     <= c_rd;
						state_q <= S_BSET;
					end else if (f_q == '0) begin
						state_q <= S_BSET;
					end else begin
						state_q <= S_BFW;
					end
				end
				S_BSET: state_q <= S_BL1;
				S_BL1: begin
					lf_q    <= l_rd;
					state_q <= S_BL2;
				end
				S_BL2: begin
					if (int'(tail_q) < NODES) begin
						tail_q <= tail_q + 1'b1;
					end
					if (int'(i_q) == ALPHABET - 1) begin
						state_q <= S_BPOP;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_BKID;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register, loaded once the previous result is taken
	always_ff @(posedge clk) begin
		if (fin_q && out_free) begin
			match_length_q <= len_ext[7:0];
			status_q       <= pend_st_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign match_length = match_length_q;
	assign status       = status_q;

endmodule
`default_nettype wire

// ===== tb/mplm_checker.sv =====
// mplm_checker: watches the request and result channels of the longest-match block,
// keeps its own trie/automaton copy and compares every result in order
// depends on mplm_pkg
module mplm_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic       req_stall,
	input  wire logic [1:0] func,
	input  wire logic [4:0] symbol,
	input  wire logic       last_of_pattern,
	input  wire logic       new_text,
	input  wire logic       res_valid,
	input  wire logic       res_stall,
	input  wire logic [7:0] match_length,
	input  wire logic [1:0] status,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NN = mplm_pkg::NODES_DEF;
	localparam int NA = mplm_pkg::ALPHABET_DEF;

	typedef struct packed {
		logic [7:0] len;
		logic [1:0] st;
	} answer_t;

	logic [9:0] kids [NN*NA];
	logic [9:0] fail_of [NN];
	logic [7:0] best_len [NN];
	int nodes_used, cursor, scan_node, pat_len;
	bit pat_dropped;
	answer_t answers_due [$];

	assign pending = answers_due.size();

	function automatic int child(int node, int sym);
		if (node >= NN || sym >= NA) return 0;
		return int'(kids[node*NA + sym]);
	endfunction

	function automatic answer_t predict(logic [1:0] f, int sym, bit last, bit restart);
		answer_t a;
		int nx, cur, head, tail, fl, g;
		int order [NN];
		a = '0;
		case (mplm_pkg::func_t'(f))
			mplm_pkg::FUNC_LOAD: begin
				if (!pat_dropped) begin
					nx = child(cursor, sym);
					if (sym >= NA) pat_dropped = 1;
					else if (nx == 0) begin
						if (nodes_used + 1 < NN) begin
							nodes_used++;
							nx = nodes_used;
							kids[cursor*NA + sym] = 10'(nx);
						end else pat_dropped = 1;
					end
					if (!pat_dropped) begin
						cursor = nx;
						if (pat_len < mplm_pkg::MAX_LEN_DEF) pat_len++;
					end
				end
				if (pat_dropped) a.st = mplm_pkg::ST_FULL;
				if (last) begin
					if (!pat_dropped && cursor != 0) best_len[cursor] = 8'(pat_len);
					cursor = 0;
					pat_len = 0;
					pat_dropped = 0;
				end
			end
			mplm_pkg::FUNC_BUILD: begin
				head = 0;
				tail = 1;
				order[0] = 0;
				while (head < tail) begin
					cur = order[head++];
					for (int i = 0; i < NA; i++) begin
						nx = child(cur, i);
						if (nx == 0) continue;
						fl = 0;
						if (cur != 0) begin
							fl = int'(fail_of[cur]);
							g = 0;
							while (fl != 0 && child(fl, i) == 0 && g < NN) begin
								fl = int'(fail_of[fl]);
								g++;
							end
							if (child(fl, i) != 0) fl = child(fl, i);
						end
						fail_of[nx] = 10'(fl);
						if (best_len[fl] > best_len[nx]) best_len[nx] = best_len[fl];
						if (tail < NN) order[tail++] = nx;
					end
				end
				scan_node = 0;
				a.st = mplm_pkg::ST_BUILT;
			end
			mplm_pkg::FUNC_SCAN: begin
				cur = restart ? 0 : scan_node;
				g = 0;
				while (cur != 0 && child(cur, sym) == 0 && g < NN) begin
					cur = int'(fail_of[cur]);
					g++;
				end
				cur = child(cur, sym);
				scan_node = cur;
				a.len = best_len[cur];
			end
			default: ;
		endcase
		return a;
	endfunction

	initial begin
		foreach (kids[i]) kids[i] = '0;
		foreach (fail_of[i]) begin
			fail_of[i] = '0;
			best_len[i] = '0;
		end
		nodes_used = 0;
		cursor = 0;
		scan_node = 0;
		pat_len = 0;
		pat_dropped = 0;
		fail_count = 0;
	end

	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && req_valid && !req_stall)
			answers_due.push_back(predict(func, symbol, last_of_pattern, new_text));
		if (arst_n && res_valid && !res_stall) begin
			got = '{len: match_length, st: status};
			if (answers_due.size() == 0) begin
				$display("%0t: result with no request waiting: len %0d status %0d",
					$realtime, match_length, status);
				fail_count++;
			end else begin
				want = answers_due.pop_front();
				if (want.len !== got.len) begin
					$display("%0t: match_length expected %0d actual %0d",
						$realtime, want.len, got.len);
					fail_count++;
				end
				if (want.st !== got.st) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, want.st, got.st);
					fail_count++;
				end
			end
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for multi_pattern_longest_match
// depends on mplm_pkg, mplm_checker and the block itself
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic req_valid = 0, req_stall;
	logic [1:0] func = mplm_pkg::FUNC_LOAD;
	logic [4:0] symbol = '0;
	logic last_of_pattern = 0, new_text = 0;
	logic res_valid, res_stall = 0;
	logic [7:0] match_length;
	logic [1:0] status;
	int fail_count, pending;
	bit hold_long = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	multi_pattern_longest_match u_dut (.*);

	mplm_checker u_chk (.*);

	// a request is handed over when the edge sees valid without stall
	task automatic send(logic [1:0] f, int sym, bit last, bit restart);
		req_valid <= 1;
		func <= f;
		symbol <= sym[4:0];
		last_of_pattern <= last;
		new_text <= restart;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			req_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		gap(1);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	int burst = 0;
	task automatic item(logic [1:0] f, int sym, bit last, bit restart);
		if (burst == 0) begin
			burst = $urandom_range(1, 30);
			if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 6));
		end
		burst--;
		send(f, sym, last, restart);
	endtask

	// random word over a small alphabet slice so that patterns overlap
	task automatic load_word(int n, int span);
		for (int i = 0; i < n; i++)
			item(mplm_pkg::FUNC_LOAD, $urandom_range(0, span), i == n - 1, 0);
	endtask

	// receiver stall pattern, plus one long hold-off
	always @(posedge clk) begin
		if (hold_long) res_stall <= 1;
		else case ($urandom_range(0, 3))
			0: res_stall <= ($urandom_range(0, 1) == 1);
			1: res_stall <= ($urandom_range(0, 7) == 0);
			default: res_stall <= 0;
		endcase
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes of letters, every func, out-of-range symbols
		send(mplm_pkg::FUNC_LOAD, 0, 0, 0);
		send(mplm_pkg::FUNC_LOAD, 25, 1, 0);
		send(mplm_pkg::FUNC_LOAD, 25, 1, 0);
		send(mplm_pkg::FUNC_LOAD, 0, 0, 0);
		send(mplm_pkg::FUNC_LOAD, 31, 0, 0);
		send(mplm_pkg::FUNC_LOAD, 1, 1, 0);
		send(mplm_pkg::FUNC_LOAD, 26, 1, 0);
		send(mplm_pkg::FUNC_SCAN, 0, 0, 1);
		send(mplm_pkg::FUNC_BUILD, 0, 0, 0);
		send(mplm_pkg::FUNC_SCAN, 0, 0, 0);
		send(mplm_pkg::FUNC_SCAN, 25, 0, 0);
		send(mplm_pkg::FUNC_SCAN, 25, 0, 0);
		send(mplm_pkg::FUNC_SCAN, 31, 0, 0);
		send(mplm_pkg::FUNC_SCAN, 25, 1, 1);
		send(mplm_pkg::FUNC_NOP, 31, 1, 1);
		send(mplm_pkg::FUNC_BUILD, 0, 0, 0);
		// one long pattern to saturate the length
		for (int i = 0; i < 260; i++) send(mplm_pkg::FUNC_LOAD, 2, i == 259, 0);
		send(mplm_pkg::FUNC_BUILD, 0, 0, 0);
		for (int i = 0; i < 6; i++) send(mplm_pkg::FUNC_SCAN, 2, 0, i == 0);
		drain();

		// long receiver hold while requests keep coming
		fork
			begin
				hold_long = 1;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end
			for (int i = 0; i < 20; i++)
				send(mplm_pkg::FUNC_SCAN, $urandom_range(0, 3), 0, 0);
		join
		drain();

		// random rounds: load words, build, scan text, with some noise
		for (int r = 0; r < 6; r++) begin
			for (int w = 0; w < 12; w++) load_word($urandom_range(1, 6), 3 + r);
			item(mplm_pkg::FUNC_BUILD, $urandom_range(0, 31), $urandom_range(0, 1), 0);
			for (int t = 0; t < 40; t++) begin
				case ($urandom_range(0, 19))
					0: item(mplm_pkg::FUNC_NOP, $urandom_range(0, 31), $urandom_range(0, 1),
						$urandom_range(0, 1));
					1: item(mplm_pkg::FUNC_SCAN, $urandom_range(0, 31), 0,
						$urandom_range(0, 1));
					2: item(mplm_pkg::FUNC_LOAD, $urandom_range(0, 25),
						$urandom_range(0, 1), 0);
					default: item(mplm_pkg::FUNC_SCAN, $urandom_range(0, 3 + r), 0,
						$urandom_range(0, 15) == 0);
				endcase
			end
		end
		drain();
		// fill the trie to overflow with long random words
		for (int w = 0; w < 30; w++) load_word($urandom_range(20, 40), 25);
		item(mplm_pkg::FUNC_BUILD, 0, 0, 0);
		for (int t = 0; t < 150; t++)
			item(mplm_pkg::FUNC_SCAN, $urandom_range(0, 25), 0, $urandom_range(0, 31) == 0);
		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/mplm_pkg.sv
hw/rtl/mplm_ram.sv
hw/rtl/multi_pattern_longest_match.sv
tb/mplm_checker.sv
tb/tb_top.sv
